FILE: sv/olad_pkg.sv
// ----------------------------------------------------------------------------
// olad_pkg: shared types and constants for the ordered list block
// Capacity, index widths, command and status codes, and item structs.
// ----------------------------------------------------------------------------
package olad_pkg;

  // Number of entries the list can hold.
  localparam int unsigned Capacity = 32;

  // Width of a memory address and of a count that can reach Capacity.
  localparam int unsigned IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW = $clog2(Capacity + 1);

  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    OpAppend = 2'd0,
    OpList   = 2'd1,
    OpDelete = 2'd2
  } opcode_e;

  // The fourth opcode has no meaning; the block accepts and ignores it.
  localparam logic [1:0] OpUnused = 2'd3;

  typedef enum logic [2:0] {
    StAppended = 3'd0,
    StFull     = 3'd1,
    StRemoved  = 3'd2,
    StNotFound = 3'd3,
    StEntry    = 3'd4,
    StEmpty    = 3'd5
  } status_e;

  // Input item: the opcode stays a raw field so that the unused code passes.
  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [DataW-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [2:0]              status;
    logic signed [DataW-1:0] entry_value;
    logic                    last;
  } result_t;

endpackage

FILE: sv/ordered_list_append_delete.sv
// ----------------------------------------------------------------------------
// ordered_list_append_delete: ordered list with append, delete and list
// Keeps up to Capacity signed words in insertion order in one synchronous
// memory and walks it with a small sequencer for list and delete commands.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                     Payload
// command   in         start_i high while busy_o low  cmd_i    (olad_pkg::cmd_t)
// result    out        result_valid_o, one cycle      result_o (olad_pkg::result_t)
//
// An append item's result appears in the cycle after the item is accepted,
// and busy_o stays low, so appends can arrive every cycle.
// A list item of N entries holds busy_o high and emits one entry each cycle;
// the single memory read port sets this rate.
// A delete item reads entries one per cycle until it finds a match, then
// moves each later entry down by one.
// Reset clears the entry count and the sequencer; the memory keeps no reset
// and data past the count goes unused. The receiver cannot stall results.

module ordered_list_append_delete (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  olad_pkg::cmd_t    cmd_i,
  output logic              busy_o,
  output logic              result_valid_o,
  output olad_pkg::result_t result_o
);

  // One-hot sequencer states.
  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StList   = 4'b0010,
    StSearch = 4'b0100,
    StShift  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Number of valid entries, and the walk pointer used by list and delete.
  logic [olad_pkg::CntW-1:0] count_q, count_d;
  logic [olad_pkg::CntW-1:0] idx_q, idx_d;
  logic [olad_pkg::CntW-1:0] idx_next;

  // Key of the delete in progress.
  logic [olad_pkg::DataW-1:0] key_q, key_d;

  // Registered result.
  logic              res_valid_q, res_valid_d;
  olad_pkg::result_t res_q, res_d;

  // Entry memory: one write port and one read port, read data registered.
  logic [olad_pkg::DataW-1:0] mem_q [olad_pkg::Capacity];
  logic [olad_pkg::DataW-1:0] rd_data_q;
  logic [olad_pkg::IdxW-1:0]  rd_addr;
  logic                       wr_en;
  logic [olad_pkg::IdxW-1:0]  wr_addr;
  logic [olad_pkg::DataW-1:0] wr_data;

  logic accept;
  logic at_last;

  assign accept   = start_i && (state_q == StIdle);
  assign idx_next = idx_q + olad_pkg::CntW'(1);
  // True when the entry now in rd_data_q is the tail of the list.
  assign at_last  = (idx_next == count_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    key_d       = key_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = count_q[olad_pkg::IdxW-1:0];
    wr_data     = cmd_i.value;

    case (state_q)
      StIdle: begin
        if (accept) begin
          res_d.entry_value = '0;
          res_d.last        = 1'b1;
          case (cmd_i.opcode)
            olad_pkg::OpAppend: begin
              res_valid_d = 1'b1;
              if (count_q >= olad_pkg::CntW'(olad_pkg::Capacity)) begin
                res_d.status = olad_pkg::StFull;
              end else begin
                wr_en        = 1'b1;
                count_d      = count_q + olad_pkg::CntW'(1);
                res_d.status = olad_pkg::StAppended;
              end
            end
            olad_pkg::OpList: begin
              if (count_q == '0) begin
                res_valid_d  = 1'b1;
                res_d.status = olad_pkg::StEmpty;
              end else begin
                // Fetch the head into rd_data_q; StList then registers it as a result.
                idx_d   = '0;
                state_d = StList;
              end
            end
            olad_pkg::OpDelete: begin
              if (count_q == '0) begin
                res_valid_d  = 1'b1;
                res_d.status = olad_pkg::StNotFound;
              end else begin
                key_d   = cmd_i.value;
                idx_d   = '0;
                state_d = StSearch;
              end
            end
            default: begin
              // The unused opcode has no effect and no result.
            end
          endcase
        end
      end

      StList: begin
        // rd_data_q holds entry idx_q; fetch the following one meanwhile.
        res_valid_d       = 1'b1;
        res_d.status      = olad_pkg::StEntry;
        res_d.entry_value = $signed(rd_data_q);
        res_d.last        = at_last;
        rd_addr           = idx_next[olad_pkg::IdxW-1:0];
        idx_d             = idx_next;
        if (at_last) begin
          state_d = StIdle;
        end
      end

      StSearch: begin
        res_d.entry_value = '0;
        res_d.last        = 1'b1;
        rd_addr           = idx_next[olad_pkg::IdxW-1:0];
        idx_d             = idx_next;
        if (rd_data_q == key_q) begin
          if (at_last) begin
            // The match is the tail: dropping it needs no moves.
            count_d      = count_q - olad_pkg::CntW'(1);
            res_valid_d  = 1'b1;
            res_d.status = olad_pkg::StRemoved;
            state_d      = StIdle;
          end else begin
            state_d = StShift;
          end
        end else if (at_last) begin
          res_valid_d  = 1'b1;
          res_d.status = olad_pkg::StNotFound;
          state_d      = StIdle;
        end
      end

      StShift: begin
        // Move entry idx_q down into the slot below it. The write goes one
        // entry below and the read one entry above, so they never collide.
        wr_en   = 1'b1;
        wr_addr = idx_q[olad_pkg::IdxW-1:0] - olad_pkg::IdxW'(1);
        wr_data = rd_data_q;
        rd_addr = idx_next[olad_pkg::IdxW-1:0];
        idx_d   = idx_next;
        if (at_last) begin
          count_d           = count_q - olad_pkg::CntW'(1);
          res_valid_d       = 1'b1;
          res_d.status      = olad_pkg::StRemoved;
          res_d.entry_value = '0;
          res_d.last        = 1'b1;
          state_d           = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    key_q <= key_d;
    res_q <= res_d;
  end

  assign busy_o         = (state_q != StIdle);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

FILE: sv/olad_checker.sv
// ----------------------------------------------------------------------------
// olad_checker: port-level checks for the ordered list block
// Watches commands and results over time and is bound to the top level.
// ----------------------------------------------------------------------------
module olad_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input olad_pkg::cmd_t    cmd_i,
  input logic              busy_o,
  input logic              result_valid_o,
  input olad_pkg::result_t result_o
);

  logic accepted;
  assign accepted = start_i && !busy_o;

  // Every result other than a listed entry is the only one for its item.
  a_single_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.status != olad_pkg::StEntry) |-> result_o.last)
    else $error("non-entry result without last");

  a_single_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.status != olad_pkg::StEntry)
      |-> (result_o.entry_value == '0))
    else $error("non-entry result carries a value");

  // An append answers in the very next cycle.
  a_append_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accepted && (cmd_i.opcode == olad_pkg::OpAppend)
      |=> result_valid_o && ((result_o.status == olad_pkg::StAppended) ||
                             (result_o.status == olad_pkg::StFull)))
    else $error("append result missing");

  // The unused opcode produces nothing.
  a_unused_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accepted && (cmd_i.opcode == olad_pkg::OpUnused) |=> !result_valid_o)
    else $error("result for unused opcode");

  // A multi-cycle item ends exactly with its final result.
  a_busy_ends_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> result_valid_o && result_o.last)
    else $error("busy dropped without final result");

endmodule

bind ordered_list_append_delete olad_checker u_olad_checker (.*);

FILE: sim/olad_result_checker.sv
// ----------------------------------------------------------------------------
// olad_result_checker: command and result monitor for the ordered list block
// Keeps its own copy of the list, works out the results that each accepted
// command owes, and compares every strobed result with the oldest one owed.
// ----------------------------------------------------------------------------
module olad_result_checker
  import olad_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  cmd_t    cmd_i,
  input  logic    busy_i,
  input  logic    result_valid_i,
  input  result_t result_i,
  output int      fail_count_o,
  output int      owed_count_o
);

  logic signed [DataW-1:0] stored_q[$];
  result_t                 owed_results_q[$];

  function automatic result_t make_result(status_e status, logic signed [DataW-1:0] value,
                                          logic last);
    result_t res;
    res.status      = status;
    res.entry_value = value;
    res.last        = last;
    return res;
  endfunction

  task automatic flag(string what);
    $display("%0t: mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  // Applies one accepted command to the stored list and queues the results it owes.
  task automatic apply_cmd(cmd_t cmd);
    int hit;
    hit = -1;
    case (cmd.opcode)
      OpAppend: begin
        if (stored_q.size() >= Capacity) begin
          owed_results_q.push_back(make_result(StFull, '0, 1'b1));
        end else begin
          stored_q.push_back(cmd.value);
          owed_results_q.push_back(make_result(StAppended, '0, 1'b1));
        end
      end
      OpList: begin
        if (stored_q.size() == 0) begin
          owed_results_q.push_back(make_result(StEmpty, '0, 1'b1));
        end else begin
          foreach (stored_q[i]) begin
            owed_results_q.push_back(make_result(StEntry, stored_q[i],
                                                 i == stored_q.size() - 1));
          end
        end
      end
      OpDelete: begin
        // Only the match nearest the head goes; the queue closes the gap.
        foreach (stored_q[i]) begin
          if (hit < 0 && stored_q[i] == cmd.value) hit = i;
        end
        if (hit < 0) begin
          owed_results_q.push_back(make_result(StNotFound, '0, 1'b1));
        end else begin
          stored_q.delete(hit);
          owed_results_q.push_back(make_result(StRemoved, '0, 1'b1));
        end
      end
      default: ;
    endcase
  endtask

  task automatic take_result();
    result_t want;
    if (owed_results_q.size() == 0) begin
      flag($sformatf("result with none owed: status %0d entry %0d last %0b",
                     result_i.status, result_i.entry_value, result_i.last));
      return;
    end
    want = owed_results_q.pop_front();
    if (result_i.status !== want.status)
      flag($sformatf("status %0d, expected %0d", result_i.status, want.status));
    if (result_i.entry_value !== want.entry_value)
      flag($sformatf("entry_value %0d, expected %0d", result_i.entry_value,
                     want.entry_value));
    if (result_i.last !== want.last)
      flag($sformatf("last %0b, expected %0b", result_i.last, want.last));
  endtask

  // Results are checked before the command of the same edge is applied, since
  // a result can never come out in the cycle its command is accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_i !== 1'b0) take_result();
      if (start_i && busy_i === 1'b0) apply_cmd(cmd_i);
      owed_count_o = owed_results_q.size();
    end
  end

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: top level of the ordered list testbench
// Drives directed and random append, list and delete items into the block,
// with and without idle gaps, and takes the verdict from the result checker.
// ----------------------------------------------------------------------------
module tb;
  import olad_pkg::*;

  // The slowest correct run is a few hundred items, each at most a full list
  // plus the longest sender gap, so this limit leaves a wide margin.
  localparam int CycleLimit  = 200000;
  // After the last result, a delete or a list may still be finishing its walk
  // over the memory; a stray result would show up before this wait runs out.
  localparam int DrainCycles = 2 * Capacity + 16;

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    start_i;
  cmd_t    cmd_i;
  logic    busy_o;
  logic    result_valid_o;
  result_t result_o;

  int fail_count;
  int owed_count;
  int cycle_cnt = 0;
  int sender_idle_pct = 0;

  // Recently appended values, so that most deletes aim at a stored entry.
  logic signed [DataW-1:0] appended_q[$];

  always #5 clk_i = ~clk_i;

  ordered_list_append_delete i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .cmd_i          (cmd_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  olad_result_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .cmd_i          (cmd_i),
    .busy_i         (busy_o),
    .result_valid_i (result_valid_o),
    .result_i       (result_o),
    .fail_count_o   (fail_count),
    .owed_count_o   (owed_count)
  );

  // Issues one item, called at a falling edge. With a chance set by the idle rate
  // the sender first drops start for a random gap. The item is held until a rising
  // edge sees busy low, and the task returns at the following falling edge, so
  // start is assigned at most once per time step even for back-to-back items.
  task automatic send(logic [1:0] op, logic signed [DataW-1:0] val);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    start_i      <= 1'b1;
    cmd_i.opcode <= op;
    cmd_i.value  <= val;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    @(negedge clk_i);
    if (op == OpAppend) begin
      appended_q.push_back(val);
      if (appended_q.size() > 64) void'(appended_q.pop_front());
    end
  endtask

  // Holds the sender off until every owed result has come out. The first wait
  // keeps the lowering of start apart from the raise of the next item.
  task automatic wait_drained();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (owed_count != 0) @(negedge clk_i);
  endtask

  // Mostly full-width random values, with the extremes mixed in. The narrow
  // range makes duplicates common, so delete has to pick the one at the head.
  function automatic logic signed [DataW-1:0] pick_value(bit narrow);
    int unsigned r;
    r = $urandom_range(15);
    if (narrow) return $urandom_range(7);
    if (r == 0) return {1'b1, {(DataW-1){1'b0}}};
    if (r == 1) return {1'b0, {(DataW-1){1'b1}}};
    if (r == 2) return '0;
    if (r == 3) return '1;
    return $urandom();
  endfunction

  // One phase of random items. The percentages pick append, delete and list;
  // what is left over becomes the unused opcode as noise. The phase ends with
  // the sender waiting until all owed results are out.
  task automatic run_phase(int items, int idle_pct, int app_pct, int del_pct,
                           int list_pct, bit narrow);
    int r;
    logic signed [DataW-1:0] val;
    sender_idle_pct = idle_pct;
    for (int n = 0; n < items; n++) begin
      r   = $urandom_range(99);
      val = pick_value(narrow);
      if (r < app_pct) begin
        send(OpAppend, val);
      end else if (r < app_pct + del_pct) begin
        if (appended_q.size() > 0 && $urandom_range(3) != 0)
          val = appended_q[$urandom_range(appended_q.size() - 1)];
        send(OpDelete, val);
      end else if (r < app_pct + del_pct + list_pct) begin
        send(OpList, val);
      end else begin
        send(OpUnused, val);
      end
    end
    wait_drained();
  endtask

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_ni  = 1'b0;
    start_i = 1'b0;
    cmd_i   = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, back to back. An empty list gives the empty marker, and
    // a delete on it finds nothing; the unused opcode must leave no trace.
    send(OpList, 32'sd0);
    send(OpDelete, 32'sd7);
    send(OpUnused, $urandom());
    // Both extremes, zero, minus one and a duplicated pair.
    send(OpAppend, {1'b1, {(DataW-1){1'b0}}});
    send(OpAppend, {1'b0, {(DataW-1){1'b1}}});
    send(OpAppend, 32'sd0);
    send(OpAppend, -32'sd1);
    send(OpAppend, 32'sd5);
    send(OpAppend, 32'sd5);
    send(OpAppend, 32'sd9);
    send(OpList, $urandom());
    // Only the first of the two fives may go.
    send(OpDelete, 32'sd5);
    send(OpList, 32'sd0);
    send(OpDelete, 32'sd1234);
    // Removal at the head and at the tail.
    send(OpDelete, {1'b1, {(DataW-1){1'b0}}});
    send(OpDelete, 32'sd9);
    send(OpUnused, -32'sd1);
    send(OpList, 32'sd0);
    // Empty the list again and list it once more.
    send(OpDelete, {1'b0, {(DataW-1){1'b1}}});
    send(OpDelete, 32'sd0);
    send(OpDelete, -32'sd1);
    send(OpDelete, 32'sd5);
    send(OpList, 32'sd0);
    wait_drained();

    // Random part. The first phase grows the list well past full with no
    // gaps, so that full drops and long lists are common; the later ones
    // shrink it, churn it with duplicates, and fill it again under gaps.
    run_phase(60,  0, 80, 10,  8, 1'b0);
    run_phase(60, 66, 20, 60, 17, 1'b0);
    run_phase(60, 20, 45, 40, 12, 1'b1);
    run_phase(60,  0, 50, 35, 12, 1'b0);
    run_phase(60, 66, 85,  5,  8, 1'b0);

    // Everything owed has arrived; give a late or stray result time to show.
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
